// File: rtl/hdh_pkg.sv
package hdh_pkg;

	// register indexes on the configuration channel
	localparam logic [7:0] REG_ARM_THRESHOLD   = 8'd0;
	localparam logic [7:0] REG_START_THRESHOLD = 8'd1;
	localparam logic [7:0] REG_ABORT_THRESHOLD = 8'd2;
	localparam logic [7:0] REG_RUN_DURATION    = 8'd3;

	// reset values of the configuration registers
	localparam logic [9:0]  ARM_THRESHOLD_RST   = 10'd500;
	localparam logic [9:0]  START_THRESHOLD_RST = 10'd400;
	localparam logic [9:0]  ABORT_THRESHOLD_RST = 10'd800;
	localparam logic [31:0] RUN_DURATION_RST    = 32'd5400000;

	// stream payload widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic [9:0]  arm_threshold;
		logic [9:0]  start_threshold;
		logic [9:0]  abort_threshold;
		logic [31:0] run_duration_ms;
	} cfg_t;

	typedef struct packed {
		logic [15:0] completed_runs;
		logic        armed;
		logic        run_aborted;
		logic        run_finished;
		logic        heater_on;
	} result_t;

endpackage

// File: rtl/hdh_cfg_regs.sv
module hdh_cfg_regs
	import hdh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [7:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_threshold   <= ARM_THRESHOLD_RST;
			cfg_q.start_threshold <= START_THRESHOLD_RST;
			cfg_q.abort_threshold <= ABORT_THRESHOLD_RST;
			cfg_q.run_duration_ms <= RUN_DURATION_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ARM_THRESHOLD:   cfg_q.arm_threshold   <= wr_data[9:0];
				REG_START_THRESHOLD: cfg_q.start_threshold <= wr_data[9:0];
				REG_ABORT_THRESHOLD: cfg_q.abort_threshold <= wr_data[9:0];
				REG_RUN_DURATION:    cfg_q.run_duration_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/hdh_core.sv
module hdh_core
	import hdh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [9:0]  humidity,
	input  logic [31:0] now_ms,
	input  cfg_t        cfg,
	output result_t     res
);

	logic        armed_q;
	logic        running_q;
	logic [31:0] start_time_q;
	logic [15:0] run_cnt_q;

	logic        arm_a, start_a, run_a;
	logic        abort_b, arm_b, run_b;
	logic        active, done;
	logic        arm_c, run_c;
	logic [31:0] start_time_a;
	logic [31:0] elapsed;
	logic [15:0] run_cnt_c;

	// arm and start
	assign arm_a        = armed_q | (humidity > cfg.arm_threshold);
	assign start_a      = arm_a & ~running_q & (humidity <= cfg.start_threshold);
	assign run_a        = running_q | start_a;
	assign start_time_a = start_a ? now_ms : start_time_q;

	// protection
	assign abort_b = run_a & (humidity > cfg.abort_threshold);
	assign run_b   = run_a & ~abort_b;
	assign arm_b   = arm_a & ~abort_b;

	// timeout on the wrapping elapsed time
	assign elapsed   = now_ms - start_time_a;
	assign active    = run_b & arm_b;
	assign done      = active & (elapsed >= cfg.run_duration_ms);
	assign run_c     = run_b & ~done;
	assign arm_c     = arm_b & ~done;
	assign run_cnt_c = run_cnt_q + {15'd0, done};

	always_comb begin
		res.heater_on      = active & ~done;
		res.run_finished   = done;
		res.run_aborted    = abort_b;
		res.armed          = arm_c;
		res.completed_runs = run_cnt_c;
	end

	// controller state, updated once per period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			running_q    <= 1'b0;
			start_time_q <= 32'd0;
			run_cnt_q    <= 16'd0;
		end else if (step) begin
			armed_q      <= arm_c;
			running_q    <= run_c;
			start_time_q <= start_time_a;
			run_cnt_q    <= run_cnt_c;
		end
	end

`ifndef SYNTHESIS
	a_finish_abort_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(res.run_finished && res.run_aborted))
		else $error("run finished and aborted in one period");

	a_heater_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.heater_on |=> armed_q && running_q)
		else $error("heater on without an armed running cycle");

	a_count_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.run_finished |=> run_cnt_q == $past(run_cnt_q) + 16'd1)
		else $error("completed run not counted");

	a_abort_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.run_aborted |=> !running_q && !armed_q)
		else $error("abort left the cycle running or armed");
`endif

endmodule

// File: rtl/humidity_triggered_drying_heater_top.sv
// Humidity-triggered drying heater controller.
// Input stream s_axis: one transfer per control period carrying the humidity
// sample and the free-running millisecond time. Output stream m_axis: exactly
// one result transfer per input transfer, in order, with heater drive, the
// finish and abort pulses, the armed flag and the completed run count.
// Configuration channel cfg_*: register index and write data, always ready;
// write only while no period is in flight. Index 0 arm, 1 start, 2 abort
// threshold (low 10 bits used), 3 run duration in ms; other indexes ignored.
// The input register holds the period; the update is computed from it and
// captured into the result register. Throughput: one period per cycle while
// m_axis_tready stays high; the state update is a single compare and 32-bit
// subtract pass between the input and result registers.
// Reset clears the armed and running flags, the run start time, the run
// count and restores the register defaults; both streams come up empty.
// When the receiver stalls, the result register holds, the input register
// fills behind it and s_axis_tready drops until the result is taken.
module humidity_triggered_drying_heater_top
	import hdh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // humidity[9:0], now_ms[41:10], zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // heater_on, run_finished, run_aborted,
	                                             // armed, completed_runs[19:4], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	cfg_t        cfg;
	result_t     res;
	logic        valid_s1;
	logic [9:0]  humidity_s1;
	logic [31:0] now_ms_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;

	assign cfg_ready = 1'b1;

	hdh_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// period moves on when the result register is free or being drained
	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			humidity_s1 <= s_axis_tdata[9:0];
			now_ms_s1   <= s_axis_tdata[41:10];
		end
	end

	hdh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.humidity (humidity_s1),
		.now_ms   (now_ms_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, res_s2};

	// the unused upper input bits are padding
	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[IN_DATA_W-1:42];

endmodule

// File: sim/humidity_triggered_drying_heater_top_tb.sv
`timescale 1ns / 100ps

module humidity_triggered_drying_heater_top_tb;
	import hdh_pkg::*;

	localparam int          CYCLE_LIMIT = 1_000_000;
	// an index that maps to no register
	localparam logic [7:0]  REG_UNUSED  = 8'hFF;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // humidity[9:0], now_ms[41:10], zero pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // heater_on, run_finished, run_aborted,
	                                       // armed, completed_runs[19:4], zero pad
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [7:0]            cfg_index;
	logic [31:0]           cfg_data;

	humidity_triggered_drying_heater_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// controller state as the testbench expects it
	cfg_t        dev_cfg;
	logic        ctl_armed;
	logic        ctl_running;
	logic [31:0] ctl_start_ms;
	logic [15:0] ctl_runs;

	result_t     expected_status[$];

	// sender and receiver pacing
	int          gap_max;
	int          burst_left;
	rx_mode_t    rx_mode;
	logic [7:0]  rx_pattern;
	int          rx_hold_left;
	logic [31:0] traffic_ms;

	// bookkeeping
	int          cycles;
	int          mismatches;
	int          periods_sent;
	int          results_seen;
	int          runs_finished_seen;
	int          runs_aborted_seen;
	int          writes_done;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				expected_status.size());
			$display("humidity_triggered_drying_heater_top regression: fail");
			$finish;
		end
	end

	// one control period: arm/start, protection, then heater and timeout
	function automatic result_t predict_period(input logic [9:0] hum, input logic [31:0] stamp);
		result_t     r;
		logic [31:0] elapsed;
		r = '0;
		if (hum > dev_cfg.arm_threshold)
			ctl_armed = 1'b1;
		if (ctl_armed && !ctl_running && hum <= dev_cfg.start_threshold) begin
			ctl_running  = 1'b1;
			ctl_start_ms = stamp;
		end
		if (ctl_running && hum > dev_cfg.abort_threshold) begin
			ctl_running   = 1'b0;
			ctl_armed     = 1'b0;
			r.run_aborted = 1'b1;
		end
		if (ctl_running && ctl_armed) begin
			elapsed     = stamp - ctl_start_ms;
			r.heater_on = 1'b1;
			if (elapsed >= dev_cfg.run_duration_ms) begin
				r.heater_on    = 1'b0;
				ctl_running    = 1'b0;
				ctl_armed      = 1'b0;
				r.run_finished = 1'b1;
				ctl_runs       = ctl_runs + 16'd1;
			end
		end
		r.armed          = ctl_armed;
		r.completed_runs = ctl_runs;
		return r;
	endfunction

	// output side: check each transfer, then pick the next ready
	always @(posedge clk) begin : result_side
		result_t got;
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[19:0];
			results_seen++;
			if (got.run_finished === 1'b1)
				runs_finished_seen++;
			if (got.run_aborted === 1'b1)
				runs_aborted_seen++;
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %0d: %h", results_seen, got);
			end else begin
				want = expected_status.pop_front();
				if (got.heater_on !== want.heater_on || got.run_finished !== want.run_finished ||
				    got.run_aborted !== want.run_aborted || got.armed !== want.armed ||
				    got.completed_runs !== want.completed_runs) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d mismatch: expected heater %b finished %b aborted %b",
							" armed %b runs %0d, got heater %b finished %b aborted %b armed %b",
							" runs %0d"}, results_seen,
							want.heater_on, want.run_finished, want.run_aborted, want.armed,
							want.completed_runs, got.heater_on, got.run_finished,
							got.run_aborted, got.armed, got.completed_runs);
				end
			end
		end
		// long hold-off first, then the current stall style
		rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  m_axis_tready <= 1'b1;
				RX_RANDOM:  m_axis_tready <= ($urandom_range(99, 0) < 60);
				default:    m_axis_tready <= rx_pattern[0];
			endcase
		end
	end

	// offer one period and wait for its transfer
	task automatic send_period(input logic [9:0] hum, input logic [31:0] stamp);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, stamp, hum};
		do @(posedge clk); while (!s_axis_tready);
		expected_status.push_back(predict_period(hum, stamp));
		periods_sent++;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(gap_max, 1)) @(posedge clk);
				burst_left = $urandom_range(16, 0);
			end else begin
				burst_left--;
			end
		end
	endtask

	// stop sending and let every expected result come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes
	task automatic write_register(input logic [7:0] index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		writes_done++;
		case (index)
			REG_ARM_THRESHOLD:   dev_cfg.arm_threshold   = value[9:0];
			REG_START_THRESHOLD: dev_cfg.start_threshold = value[9:0];
			REG_ABORT_THRESHOLD: dev_cfg.abort_threshold = value[9:0];
			REG_RUN_DURATION:    dev_cfg.run_duration_ms = value;
			default: ;
		endcase
	endtask

	// all four registers, upper bits of the threshold words filled with noise
	task automatic load_settings(input logic [9:0] arm_lvl, input logic [9:0] start_lvl,
		input logic [9:0] abort_lvl, input logic [31:0] dur);
		write_register(REG_ARM_THRESHOLD,   {22'($urandom), arm_lvl});
		write_register(REG_START_THRESHOLD, {22'($urandom), start_lvl});
		write_register(REG_ABORT_THRESHOLD, {22'($urandom), abort_lvl});
		write_register(REG_RUN_DURATION,    dur);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [9:0] hum_above(input logic [9:0] thr);
		if (thr == 10'd1023)
			return 10'($urandom_range(1023, 0));
		return 10'($urandom_range(1023, int'(thr) + 1));
	endfunction

	function automatic logic [9:0] hum_at_or_below(input logic [9:0] thr);
		return 10'($urandom_range(int'(thr), 0));
	endfunction

	// mostly well-formed arm / start / run sequences, some noise
	task automatic drive_drying_traffic(input int count);
		logic [9:0]  hum;
		logic [31:0] stamp;
		int          roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99, 0);
			if (roll < 12) begin
				hum   = 10'($urandom_range(1023, 0));
				stamp = $urandom;
			end else begin
				if (!ctl_armed)
					hum = (roll < 80) ? hum_above(dev_cfg.arm_threshold) : 10'($urandom);
				else if (!ctl_running)
					hum = (roll < 85) ? hum_at_or_below(dev_cfg.start_threshold) : 10'($urandom);
				else if (roll < 20)
					hum = hum_above(dev_cfg.abort_threshold);
				else
					hum = hum_at_or_below(dev_cfg.abort_threshold);
				// step time, sometimes straight to the run boundary
				if (ctl_running && $urandom_range(99, 0) < 30)
					traffic_ms = ctl_start_ms + dev_cfg.run_duration_ms +
						32'($urandom_range(2, 0)) - 32'd1;
				else
					traffic_ms = traffic_ms +
						32'($urandom_range((dev_cfg.run_duration_ms >> 3) + 32'd3, 0));
				stamp = traffic_ms;
			end
			send_period(hum, stamp);
		end
	endtask

	// default registers, arming, start, abort and a timeout across the wrap
	task automatic test_default_registers();
		rx_mode = RX_RANDOM;
		gap_max = 3;
		send_period(10'd0,    32'h0000_0000);
		send_period(10'd1023, 32'hFFFF_FFFF);
		send_period(10'd400,  32'hFFFF_FF00);
		send_period(10'd800,  32'h0000_0100);
		send_period(10'd801,  32'h0000_0200);
		send_period(10'd501,  32'h0000_0005);
		send_period(10'd401,  32'h0000_000A);
		send_period(10'd400,  32'hFFFF_FFF0);
		send_period(10'd0,    32'hFFFF_FFF0 + 32'd5_399_999);
		send_period(10'd0,    32'hFFFF_FFF0 + 32'd5_400_000);
		drain_results();
	endtask

	// arm and start together, zero duration, abort beats timeout, saturating compares
	task automatic test_special_cases();
		load_settings(10'd300, 10'd600, 10'd1023, 32'd0);
		send_period(10'd450,  32'd100);
		send_period(10'd1023, 32'd200);
		drain_results();
		load_settings(10'd50, 10'd900, 10'd100, 32'd0);
		send_period(10'd500, 32'd300);
		drain_results();
		// ignored index, then full-scale duration and abort level
		write_register(REG_UNUSED, 32'd0);
		write_register(REG_ABORT_THRESHOLD, 32'h0000_FFFF);
		write_register(REG_RUN_DURATION, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_period(10'd600,  32'd1000);
		send_period(10'd1023, 32'd2000);
		send_period(10'd0,    32'd999);
		drain_results();
		write_register(REG_ARM_THRESHOLD, 32'd1023);
		cfg_valid <= 1'b0;
		send_period(10'd1023, 32'd5);
		send_period(10'd0,    32'd6);
		drain_results();
	endtask

	// output held off while the input keeps offering, then always ready
	task automatic test_output_backpressure();
		load_settings(10'd500, 10'd400, 10'd800, 32'd20);
		rx_mode      = RX_ALWAYS;
		gap_max      = 0;
		traffic_ms   = 32'd0;
		rx_hold_left = 80;
		drive_drying_traffic(24);
		drain_results();
	endtask

	// several register settings, extremes among them
	task automatic test_random_settings();
		logic [9:0]  arm_lvl;
		logic [9:0]  start_lvl;
		logic [9:0]  abort_lvl;
		logic [31:0] dur;
		for (int phase = 0; phase < 6; phase++) begin
			rx_pattern = 8'($urandom_range(255, 0)) | 8'h01;
			burst_left = 0;
			case (phase)
				0: begin
					arm_lvl   = 10'($urandom_range(700, 300));
					start_lvl = 10'($urandom_range(int'(arm_lvl), 0));
					abort_lvl = 10'($urandom_range(1023, int'(arm_lvl)));
					dur       = $urandom_range(50, 1);
					rx_mode   = RX_RANDOM;
					gap_max   = 6;
				end
				1: begin
					arm_lvl   = 10'd0;
					start_lvl = 10'd0;
					abort_lvl = 10'd1023;
					dur       = 32'd1;
					rx_mode   = RX_PATTERN;
					gap_max   = 3;
				end
				2: begin
					arm_lvl   = 10'd1000;
					start_lvl = 10'd1000;
					abort_lvl = 10'd1000;
					dur       = 32'd3;
					rx_mode   = RX_RANDOM;
					gap_max   = 8;
				end
				3: begin
					arm_lvl   = 10'($urandom);
					start_lvl = 10'($urandom);
					abort_lvl = 10'($urandom);
					dur       = $urandom_range(20, 0);
					rx_mode   = RX_ALWAYS;
					gap_max   = 0;
				end
				4: begin
					arm_lvl    = 10'd520;
					start_lvl  = 10'd380;
					abort_lvl  = 10'd850;
					dur        = RUN_DURATION_RST;
					traffic_ms = 32'hFFF0_0000;
					rx_mode    = RX_PATTERN;
					gap_max    = 4;
				end
				default: begin
					arm_lvl   = 10'($urandom_range(600, 0));
					start_lvl = 10'($urandom_range(1023, 0));
					abort_lvl = 10'($urandom_range(1023, 400));
					dur       = 32'hFFFF_FFFF;
					rx_mode   = RX_RANDOM;
					gap_max   = 5;
				end
			endcase
			load_settings(arm_lvl, start_lvl, abort_lvl, dur);
			drive_drying_traffic(100);
			drain_results();
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_mode       = RX_ALWAYS;
		rx_pattern    = 8'b1011_0110;
		rx_hold_left  = 0;
		gap_max       = 0;
		burst_left    = 0;
		traffic_ms    = '0;
		dev_cfg       = '{ARM_THRESHOLD_RST, START_THRESHOLD_RST, ABORT_THRESHOLD_RST,
			RUN_DURATION_RST};
		ctl_armed     = 1'b0;
		ctl_running   = 1'b0;
		ctl_start_ms  = '0;
		ctl_runs      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_special_cases();
		test_output_backpressure();
		test_random_settings();

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d control periods, %0d result transfers, %0d timed-out runs,",
			periods_sent, results_seen, runs_finished_seen);
		$display("%0d aborts, %0d register writes over six settings and a long output stall",
			runs_aborted_seen, writes_done);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("humidity_triggered_drying_heater_top regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("humidity_triggered_drying_heater_top regression: fail");
		end
		$finish;
	end

endmodule
